// ===== hw/rtl/gbl_pkg.sv =====
// shared constants, types and helper functions of the 5x5 gaussian blur
`default_nettype none

package gbl_pkg;

	// geometry
	localparam int MAX_WIDTH   = 2048;
	localparam int KERNEL_SIZE = 5;
	localparam int HALF_K      = KERNEL_SIZE / 2;
	localparam int NUM_SLOTS   = KERNEL_SIZE - 1;
	localparam int SLOT_W      = $clog2(NUM_SLOTS);
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int WID_W       = COL_W + 1;
	localparam int DIM_W       = 12;
	localparam int EXT_W       = DIM_W + WID_W;
	localparam int LAG_W       = WID_W + 1;
	localparam int MIN_DIM     = KERNEL_SIZE;

	// datapath widths
	localparam int PIX_W     = 8;
	localparam int PIX_MAX   = 2 ** PIX_W - 1;
	localparam int WGT_W     = 16;
	localparam int FRAC_W    = 16;
	localparam int PAIR_W    = PIX_W + 1;
	localparam int PROD_W    = PAIR_W + WGT_W;
	localparam int COL_SUM_W = PROD_W + 2;
	localparam int SUM_W     = COL_SUM_W + $clog2(KERNEL_SIZE);

	// configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT,
		REG_WEIGHT_CENTER,
		REG_WEIGHT_AXIS_ONE,
		REG_WEIGHT_DIAGONAL_ONE,
		REG_WEIGHT_AXIS_TWO,
		REG_WEIGHT_KNIGHT,
		REG_WEIGHT_DIAGONAL_TWO
	} cfg_reg_t;

	// weight slots
	localparam int W_CENTER        = 0;
	localparam int W_AXIS_ONE      = 1;
	localparam int W_DIAGONAL_ONE  = 2;
	localparam int W_AXIS_TWO      = 3;
	localparam int W_KNIGHT        = 4;
	localparam int W_DIAGONAL_TWO  = 5;
	localparam int NUM_WEIGHTS     = 6;

	typedef logic [WGT_W-1:0] weight_t;

	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;
	localparam weight_t WEIGHT_RESET [NUM_WEIGHTS] = '{
		16'd10623, 16'd6443, 16'd3908, 16'd1438, 16'd872, 16'd195
	};

	// result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} out_item_t;

	// width register keeps the clamped value
	function automatic logic [WID_W-1:0] clamp_width(input logic [DIM_W-1:0] v);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(v);
		if (ext < EXT_W'(MIN_DIM)) return WID_W'(MIN_DIM);
		if (ext > EXT_W'(MAX_WIDTH)) return WID_W'(MAX_WIDTH);
		return WID_W'(ext);
	endfunction

	function automatic logic [DIM_W-1:0] clamp_height(input logic [DIM_W-1:0] v);
		return (v < DIM_W'(MIN_DIM)) ? DIM_W'(MIN_DIM) : v;
	endfunction

	// weight slot for a tap at row distance ady and column distance adx
	function automatic int weight_sel(input int ady, input int adx);
		int lo;
		int hi;
		lo = (ady < adx) ? ady : adx;
		hi = (ady < adx) ? adx : ady;
		if (hi == 0) return W_CENTER;
		if (hi == 1) return (lo == 0) ? W_AXIS_ONE : W_DIAGONAL_ONE;
		if (lo == 0) return W_AXIS_TWO;
		if (lo == 1) return W_KNIGHT;
		return W_DIAGONAL_TWO;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gbl_ram.sv =====
// generic simple dual-port ram with registered read (old data on collision)
`default_nettype none

module gbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/gbl_cell.sv =====
// one column cell of the transposed kernel chain
`default_nettype none

module gbl_cell import gbl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  weight_t           w_mid,
	input  weight_t           w_near,
	input  weight_t           w_far,
	input  logic [PIX_W-1:0]  x_mid,
	input  logic [PAIR_W-1:0] x_near,
	input  logic [PAIR_W-1:0] x_far,
	input  logic              sum_en,
	input  logic [SUM_W-1:0]  sum_in,
	output logic [SUM_W-1:0]  sum_out
);

	logic [PROD_W-1:0]    prod_mid_s3;
	logic [PROD_W-1:0]    prod_near_s3;
	logic [PROD_W-1:0]    prod_far_s3;
	logic [COL_SUM_W-1:0] col_sum_s4;
	logic [SUM_W-1:0]     psum_q;

	// weighted column sum, row pairs pre-added upstream
	always_ff @(posedge clk) begin
		prod_mid_s3  <= PROD_W'(x_mid) * PROD_W'(w_mid);
		prod_near_s3 <= PROD_W'(x_near) * PROD_W'(w_near);
		prod_far_s3  <= PROD_W'(x_far) * PROD_W'(w_far);
		col_sum_s4   <= COL_SUM_W'(prod_mid_s3) + COL_SUM_W'(prod_near_s3)
			+ COL_SUM_W'(prod_far_s3);
	end

	// partial sum moves one cell on per pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_q <= '0;
		end else if (sum_en) begin
			psum_q <= sum_in + SUM_W'(col_sum_s4);
		end
	end

	assign sum_out = psum_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gbl_fifo.sv =====
// small result queue between the filter pipeline and the output channel
`default_nettype none

module gbl_fifo import gbl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_item,
	input  logic      pop,
	output logic      valid,
	output out_item_t head
);

	out_item_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== hw/rtl/gaussian_blur_5x5.sv =====
// gaussian_blur_5x5: streaming 5x5 gaussian blur of 8-bit grayscale pixels
//
// input channel (pix_valid / pix_stall): one transaction per pixel in raster
// order (mode 0), or a drain tick (mode 1) that flushes one pending pixel
// output channel (res_valid / res_stall): filtered or passed-through pixels
// in raster order; frame_last marks the last pixel of each frame
// the output stream trails the input by two rows and two pixels; pixels
// within two rows or columns of the border pass through unchanged
// throughput is one transaction per clock while pix_stall is low; a result
// is registered through the pipeline stages and queued before it leaves
// the rate is set by the four row rams (all read once per transaction, one
// written per pixel) and the five-cell multiply chain, one column per clock
// a stalled receiver fills an eight-entry result queue; the input stalls only
// once queue plus pipeline hold eight transactions, never on res_stall itself
// reset restores the sigma one kernel and 640x480, clears counters, queue
// and partial sums; the row rams are not cleared (no clearing pass)
// configuration writes are registered and are meant for idle periods
`default_nettype none

module gaussian_blur_5x5 import gbl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// pixel input channel
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  logic                 mode,
	input  logic [PIX_W-1:0]     pixel_in,
	// result channel
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [PIX_W-1:0]     pixel_out,
	output logic                 frame_last,
	// configuration write port
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// where a result pixel comes from
	typedef enum logic [1:0] {
		SRC_FILTER,
		SRC_CENTER,
		SRC_STORE
	} src_t;

	typedef struct packed {
		logic is_pix;
		logic emit;
		src_t src;
		logic last;
	} ctl_t;

	// ------------------------------------------------------------------
	// configuration registers (sizes are stored already clamped)
	// ------------------------------------------------------------------
	logic [WID_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	weight_t          weight_q [NUM_WEIGHTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WID_W'(WIDTH_RESET);
			height_q <= DIM_W'(HEIGHT_RESET);
			for (int i = 0; i < NUM_WEIGHTS; i++) begin
				weight_q[i] <= WEIGHT_RESET[i];
			end
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q <= clamp_width(cfg_data[DIM_W-1:0]);
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= clamp_height(cfg_data[DIM_W-1:0]);
				end
				REG_WEIGHT_CENTER:       weight_q[W_CENTER]       <= cfg_data[WGT_W-1:0];
				REG_WEIGHT_AXIS_ONE:     weight_q[W_AXIS_ONE]     <= cfg_data[WGT_W-1:0];
				REG_WEIGHT_DIAGONAL_ONE: weight_q[W_DIAGONAL_ONE] <= cfg_data[WGT_W-1:0];
				REG_WEIGHT_AXIS_TWO:     weight_q[W_AXIS_TWO]     <= cfg_data[WGT_W-1:0];
				REG_WEIGHT_KNIGHT:       weight_q[W_KNIGHT]       <= cfg_data[WGT_W-1:0];
				REG_WEIGHT_DIAGONAL_TWO: weight_q[W_DIAGONAL_TWO] <= cfg_data[WGT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// input side: raster counters, lag tracking, result decision
	// ------------------------------------------------------------------
	logic [FIFO_AW:0] pend_q;
	logic             accept;
	logic             is_pix;

	logic [COL_W-1:0]  in_col_q;
	logic [SLOT_W-1:0] in_slot_q;
	logic [COL_W-1:0]  out_col_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [DIM_W-1:0]  out_row_q;
	logic [LAG_W-1:0]  lag_q;

	logic [WID_W-1:0]  in_col_inc;
	logic              in_col_wrap;
	logic [WID_W-1:0]  out_col_inc;
	logic              out_col_wrap;
	logic [DIM_W:0]    out_row_inc;
	logic              out_row_wrap;
	logic [LAG_W-1:0]  cap;
	logic              lag_full;
	logic              interior;
	ctl_t              ctl_in;
	logic [COL_W-1:0]  line_addr;

	// the input stalls on queue credits alone
	assign pix_stall = (pend_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign accept    = pix_valid & ~pix_stall;
	assign is_pix    = ~mode;

	always_comb begin
		in_col_inc   = WID_W'(in_col_q) + WID_W'(1);
		in_col_wrap  = (in_col_inc >= width_q);
		out_col_inc  = WID_W'(out_col_q) + WID_W'(1);
		out_col_wrap = (out_col_inc >= width_q);
		out_row_inc  = (DIM_W+1)'(out_row_q) + (DIM_W+1)'(1);
		out_row_wrap = (out_row_inc >= (DIM_W+1)'(height_q));

		// results start after two rows and two pixels
		cap      = {width_q, 1'b0} + LAG_W'(HALF_K);
		lag_full = (lag_q >= cap);

		interior = (out_row_q >= DIM_W'(HALF_K))
			&& ((DIM_W+1)'(out_row_q) + (DIM_W+1)'(HALF_K) < (DIM_W+1)'(height_q))
			&& (out_col_q >= COL_W'(HALF_K))
			&& (WID_W'(out_col_q) + WID_W'(HALF_K) < width_q);

		ctl_in.is_pix = is_pix;
		ctl_in.emit   = is_pix ? lag_full : (lag_q != '0);
		ctl_in.last   = out_row_wrap & out_col_wrap;
		if (!is_pix) begin
			ctl_in.src = SRC_STORE;
		end else if (interior) begin
			ctl_in.src = SRC_FILTER;
		end else begin
			ctl_in.src = SRC_CENTER;
		end

		// a drain reads the next pending pixel back from its row ram
		line_addr = is_pix ? in_col_q : out_col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_slot_q <= '0;
			out_row_q  <= '0;
			lag_q      <= '0;
		end else if (accept) begin
			if (is_pix) begin
				if (in_col_wrap) begin
					in_col_q  <= '0;
					in_slot_q <= in_slot_q + SLOT_W'(1);
				end else begin
					in_col_q <= in_col_inc[COL_W-1:0];
				end
				// lag saturates at the cap, also after a width change
				lag_q <= lag_full ? cap : lag_q + LAG_W'(1);
			end else if (lag_q != '0) begin
				lag_q <= lag_q - LAG_W'(1);
			end
			if (ctl_in.emit) begin
				if (out_col_wrap) begin
					out_col_q  <= '0;
					out_slot_q <= out_slot_q + SLOT_W'(1);
					out_row_q  <= out_row_wrap ? '0 : out_row_inc[DIM_W-1:0];
				end else begin
					out_col_q <= out_col_inc[COL_W-1:0];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// four row rams, one per row slot; the slot being written is read
	// first, so it delivers the row four lines up
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] line_rd [NUM_SLOTS];

	for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_line
		gbl_ram #(
			.WIDTH(PIX_W),
			.DEPTH(MAX_WIDTH)
		) u_line (
			.clk    (clk),
			.wr_en  (accept & is_pix & (in_slot_q == SLOT_W'(s))),
			.wr_addr(in_col_q),
			.wr_data(pixel_in),
			.rd_en  (accept),
			.rd_addr(line_addr),
			.rd_data(line_rd[s])
		);
	end

	// ------------------------------------------------------------------
	// stage 1: ram data arrives, build the new window column
	// ------------------------------------------------------------------
	logic              v_s1;
	ctl_t              ctl_s1;
	logic [PIX_W-1:0]  pixel_s1;
	logic [SLOT_W-1:0] in_slot_s1;
	logic [SLOT_W-1:0] out_slot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1      <= ctl_in;
		pixel_s1    <= pixel_in;
		in_slot_s1  <= in_slot_q;
		out_slot_s1 <= out_slot_q;
	end

	logic [PIX_W-1:0] col_pix [KERNEL_SIZE];
	logic [PIX_W-1:0] store_pix;

	always_comb begin
		// oldest row on top, the incoming pixel at the bottom
		for (int r = 0; r < NUM_SLOTS; r++) begin
			col_pix[r] = line_rd[in_slot_s1 + SLOT_W'(r)];
		end
		col_pix[KERNEL_SIZE-1] = pixel_s1;
		store_pix = line_rd[out_slot_s1];
	end

	// window center trails the newest column by two pixels
	logic [PIX_W-1:0] cen0_q;
	logic [PIX_W-1:0] cen1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen0_q <= '0;
			cen1_q <= '0;
		end else if (v_s1 && ctl_s1.is_pix) begin
			cen0_q <= col_pix[HALF_K];
			cen1_q <= cen0_q;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: symmetric row pairs pre-added, pass-through value picked
	// ------------------------------------------------------------------
	logic              v_s2;
	ctl_t              ctl_s2;
	logic [PIX_W-1:0]  alt_s2;
	logic [PIX_W-1:0]  mid_s2;
	logic [PAIR_W-1:0] near_s2;
	logic [PAIR_W-1:0] far_s2;

	// stages 3 to 5 follow the multiply chain inside the cells
	logic             v_s3;
	logic             v_s4;
	logic             v_s5;
	ctl_t             ctl_s3;
	ctl_t             ctl_s4;
	ctl_t             ctl_s5;
	logic [PIX_W-1:0] alt_s3;
	logic [PIX_W-1:0] alt_s4;
	logic [PIX_W-1:0] alt_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2  <= ctl_s1;
		alt_s2  <= (ctl_s1.src == SRC_STORE) ? store_pix : cen1_q;
		mid_s2  <= col_pix[HALF_K];
		near_s2 <= PAIR_W'(col_pix[HALF_K-1]) + PAIR_W'(col_pix[HALF_K+1]);
		far_s2  <= PAIR_W'(col_pix[0]) + PAIR_W'(col_pix[KERNEL_SIZE-1]);
		ctl_s3  <= ctl_s2;
		alt_s3  <= alt_s2;
		ctl_s4  <= ctl_s3;
		alt_s4  <= alt_s3;
		ctl_s5  <= ctl_s4;
		alt_s5  <= alt_s4;
	end

	// ------------------------------------------------------------------
	// transposed kernel: every cell weighs the incoming column with the
	// weights of its column position and adds the partial sum of the
	// cell before it (none for the first); the last holds the full 5x5 sum
	// ------------------------------------------------------------------
	logic [SUM_W-1:0] sum_in  [KERNEL_SIZE];
	logic [SUM_W-1:0] psum    [KERNEL_SIZE];

	for (genvar k = 0; k < KERNEL_SIZE; k++) begin : g_cell
		localparam int D = (k < HALF_K) ? HALF_K - k : k - HALF_K;

		if (k == 0) begin : g_head
			assign sum_in[k] = '0;
		end else begin : g_link
			assign sum_in[k] = psum[k-1];
		end

		gbl_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.w_mid  (weight_q[weight_sel(0, D)]),
			.w_near (weight_q[weight_sel(1, D)]),
			.w_far  (weight_q[weight_sel(2, D)]),
			.x_mid  (mid_s2),
			.x_near (near_s2),
			.x_far  (far_s2),
			.sum_en (v_s4 & ctl_s4.is_pix),
			.sum_in (sum_in[k]),
			.sum_out(psum[k])
		);
	end

	// ------------------------------------------------------------------
	// stage 5: truncate, saturate, select and queue the result
	// ------------------------------------------------------------------
	logic [SUM_W-FRAC_W-1:0] filt_int;
	logic [PIX_W-1:0]        filt_pix;
	out_item_t               push_item;
	logic                    push;
	logic                    drop;
	logic                    pop;
	out_item_t               head;

	always_comb begin
		filt_int = psum[KERNEL_SIZE-1][SUM_W-1:FRAC_W];
		if (filt_int > (SUM_W-FRAC_W)'(PIX_MAX)) begin
			filt_pix = PIX_W'(PIX_MAX);
		end else begin
			filt_pix = filt_int[PIX_W-1:0];
		end
		push_item.pixel = (ctl_s5.src == SRC_FILTER) ? filt_pix : alt_s5;
		push_item.last  = ctl_s5.last;
	end

	assign push = v_s5 & ctl_s5.emit;
	assign drop = v_s5 & ~ctl_s5.emit;
	assign pop  = res_valid & ~res_stall;

	// credits: transactions accepted and not yet delivered or dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + (FIFO_AW+1)'(accept) - (FIFO_AW+1)'(pop)
				- (FIFO_AW+1)'(drop);
		end
	end

	gbl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.valid    (res_valid),
		.head     (head)
	);

	assign pixel_out  = head.pixel;
	assign frame_last = head.last;

endmodule

`default_nettype wire

// ===== verif/tb_gaussian_blur_5x5.sv =====
// self-checking testbench for the streaming 5x5 gaussian blur with random handshake timing
module tb_gaussian_blur_5x5 import gbl_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 7;
	localparam int IDLE_LIMIT    = 2000;	// cycles with no transaction on either side
	localparam int SETTLE_CYCLES = 12;	// pipeline depth plus margin
	localparam int RANDOM_ITEMS  = 400;
	localparam int MAX_PRINTS    = 100;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	// clock and reset
	logic clk;
	logic arst_n = 1'b0;

	// pixel channel, driven by the sender
	logic             pix_valid = 1'b0;
	logic             pix_stall;
	logic             mode      = MODE_PIXEL;
	logic [PIX_W-1:0] pixel_in  = '0;

	// result channel, stall driven by the receiver
	logic             res_valid;
	logic             res_stall = 1'b0;
	logic [PIX_W-1:0] pixel_out;
	logic             frame_last;

	// configuration write port
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	gaussian_blur_5x5 u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.mode       (mode),
		.pixel_in   (pixel_in),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.pixel_out  (pixel_out),
		.frame_last (frame_last),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	// ------------------------------------------------------------------
	// blur predictor: own copy of the row store, window, counters and
	// configuration, advanced once per accepted input transaction
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] model_rows [NUM_SLOTS * MAX_WIDTH] = '{default: '0};
	logic [PIX_W-1:0] model_window [KERNEL_SIZE][KERNEL_SIZE] = '{default: '{default: '0}};
	int      model_width  = WIDTH_RESET;	// already clamped
	int      model_height = HEIGHT_RESET;
	weight_t model_kernel [NUM_WEIGHTS] = WEIGHT_RESET;
	int in_col = 0, in_row = 0, in_slot = 0;
	int out_col = 0, out_row = 0, out_slot = 0;
	int model_lag = 0;	// pixels taken in but not yet put out

	out_item_t expected_pixels [$];

	// kernel that the next load_config writes
	weight_t kernel_plan [NUM_WEIGHTS];

	int  mismatch_count = 0;
	int  results_seen   = 0;
	int  sent_items     = 0;
	bit  tx_quiet       = 1'b0;	// sender runs without gaps
	bit  rx_quiet       = 1'b0;	// receiver never starts a stall
	int  hold_cycles    = 0;

	function automatic int row_addr(input int slot, input int col);
		return (slot % NUM_SLOTS) * MAX_WIDTH + col;
	endfunction

	// append one predicted result at the tail of the expected queue
	function automatic void queue_result(input out_item_t item);
		expected_pixels = {expected_pixels, item};
	endfunction

	// weight by tap distance class: far and near distance from the center
	function automatic weight_t tap_weight(input int r, input int c);
		int dy;
		int dx;
		logic [1:0] far_d;
		logic [1:0] near_d;
		dy = (r < HALF_K) ? HALF_K - r : r - HALF_K;
		dx = (c < HALF_K) ? HALF_K - c : c - HALF_K;
		far_d  = 2'((dy > dx) ? dy : dx);
		near_d = 2'((dy > dx) ? dx : dy);
		case ({far_d, near_d})
			4'b00_00: return model_kernel[W_CENTER];
			4'b01_00: return model_kernel[W_AXIS_ONE];
			4'b01_01: return model_kernel[W_DIAGONAL_ONE];
			4'b10_00: return model_kernel[W_AXIS_TWO];
			4'b10_01: return model_kernel[W_KNIGHT];
			default:  return model_kernel[W_DIAGONAL_TWO];
		endcase
	endfunction

	// truncated 0.16 weighted sum of the window, saturated to a pixel
	function automatic logic [PIX_W-1:0] blur_sum();
		logic [31:0] acc;
		acc = '0;
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			for (int c = 0; c < KERNEL_SIZE; c++) begin
				acc = acc + 32'(model_window[r][c]) * 32'(tap_weight(r, c));
			end
		end
		acc = acc >> FRAC_W;
		return (acc > PIX_MAX) ? PIX_W'(PIX_MAX) : acc[PIX_W-1:0];
	endfunction

	task automatic blur_model_step(input logic m, input logic [PIX_W-1:0] p);
		int fill_cap;
		int r;
		int c;
		logic [PIX_W-1:0] value;
		out_item_t res;
		fill_cap = 2 * model_width + 2;
		if (m == MODE_PIXEL) begin
			// shift the window left, new column from the row store plus the new pixel
			for (r = 0; r < KERNEL_SIZE; r++) begin
				for (c = 0; c < KERNEL_SIZE - 1; c++) begin
					model_window[r][c] = model_window[r][c + 1];
				end
			end
			for (r = 0; r < KERNEL_SIZE - 1; r++) begin
				model_window[r][KERNEL_SIZE - 1] = model_rows[row_addr(in_slot + r, in_col)];
			end
			model_window[KERNEL_SIZE - 1][KERNEL_SIZE - 1] = p;
			model_rows[row_addr(in_slot, in_col)] = p;
			in_col++;
			if (in_col >= model_width) begin
				in_col  = 0;
				in_slot = (in_slot + 1) % NUM_SLOTS;
				in_row++;
				if (in_row >= model_height) in_row = 0;
			end
			// still filling: two rows and two pixels must be in before any output
			if (model_lag < fill_cap) begin
				model_lag++;
				return;
			end
			model_lag = fill_cap;
			if (out_row >= HALF_K && out_row + HALF_K < model_height &&
			    out_col >= HALF_K && out_col + HALF_K < model_width) begin
				value = blur_sum();
			end else begin
				value = model_window[HALF_K][HALF_K];	// border passes through
			end
		end else begin
			// drain tick: next pending pixel straight from the row store
			if (model_lag == 0) return;
			model_lag--;
			value = model_rows[row_addr(out_slot, out_col)];
		end
		res.pixel = value;
		res.last  = (out_row + 1 >= model_height) && (out_col + 1 >= model_width);
		queue_result(res);
		out_col++;
		if (out_col >= model_width) begin
			out_col  = 0;
			out_slot = (out_slot + 1) % NUM_SLOTS;
			out_row++;
			if (out_row >= model_height) out_row = 0;
		end
	endtask

	// ------------------------------------------------------------------
	// result checking and receiver stalls
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTS) $display("mismatch @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("result %0d (pixel %0d, last %0b) with none expected",
					results_seen, pixel_out, frame_last));
			end else begin
				want = expected_pixels.pop_front();
				if (pixel_out !== want.pixel)
					report_mismatch($sformatf("result %0d pixel_out %0d, expected %0d",
						results_seen, pixel_out, want.pixel));
				if (frame_last !== want.last)
					report_mismatch($sformatf("result %0d frame_last %0b, expected %0b",
						results_seen, frame_last, want.last));
			end
			results_seen++;
		end
	end

	// stall in runs: mostly short, now and then long enough to fill the result queue
	always @(posedge clk) begin
		if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
		end else if (rx_quiet || $urandom_range(0, 99) < 65) begin
			res_stall   <= 1'b0;
			hold_cycles <= $urandom_range(0, 6);
		end else begin
			res_stall   <= 1'b1;
			hold_cycles <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
		end
	end

	// watchdog: ends the run when neither side moves for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("timeout: no transaction for %0d cycles, %0d results outstanding",
			IDLE_LIMIT, expected_pixels.size());
		$display("** gaussian_blur_5x5: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int roll;
		if (tx_quiet) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic logic [PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// one input transaction; valid stays high when the next one follows back to back
	task automatic send_item(input logic m, input logic [PIX_W-1:0] p);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		mode      <= m;
		pixel_in  <= p;
		do @(posedge clk); while (pix_stall !== 1'b0);
		if (m == MODE_PIXEL || model_lag != 0) sent_items++;
		blur_model_step(m, p);
	endtask

	// wait until every expected pixel is back and the pipeline is empty
	task automatic settle();
		pix_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		int dim;
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		dim = int'(value[DIM_W-1:0]);
		case (idx)
			REG_IMAGE_WIDTH:
				model_width = (dim < MIN_DIM) ? MIN_DIM : ((dim > MAX_WIDTH) ? MAX_WIDTH : dim);
			REG_IMAGE_HEIGHT:        model_height = (dim < MIN_DIM) ? MIN_DIM : dim;
			REG_WEIGHT_CENTER:       model_kernel[W_CENTER]       = value;
			REG_WEIGHT_AXIS_ONE:     model_kernel[W_AXIS_ONE]     = value;
			REG_WEIGHT_DIAGONAL_ONE: model_kernel[W_DIAGONAL_ONE] = value;
			REG_WEIGHT_AXIS_TWO:     model_kernel[W_AXIS_TWO]     = value;
			REG_WEIGHT_KNIGHT:       model_kernel[W_KNIGHT]       = value;
			REG_WEIGHT_DIAGONAL_TWO: model_kernel[W_DIAGONAL_TWO] = value;
			default: ;
		endcase
	endtask

	// sizes carry junk in the unused upper bits; kernel comes from kernel_plan
	task automatic load_config(input int width, input int height, input bit dims_only);
		write_reg(REG_IMAGE_WIDTH,  {4'($urandom), DIM_W'(width)});
		write_reg(REG_IMAGE_HEIGHT, {4'($urandom), DIM_W'(height)});
		if (!dims_only) begin
			write_reg(REG_WEIGHT_CENTER,       kernel_plan[W_CENTER]);
			write_reg(REG_WEIGHT_AXIS_ONE,     kernel_plan[W_AXIS_ONE]);
			write_reg(REG_WEIGHT_DIAGONAL_ONE, kernel_plan[W_DIAGONAL_ONE]);
			write_reg(REG_WEIGHT_AXIS_TWO,     kernel_plan[W_AXIS_TWO]);
			write_reg(REG_WEIGHT_KNIGHT,       kernel_plan[W_KNIGHT]);
			write_reg(REG_WEIGHT_DIAGONAL_TWO, kernel_plan[W_DIAGONAL_TWO]);
		end
	endtask

	// whole frames back to back with optional stray drain ticks, then flush the tail
	task automatic stream_frames(input int frames, input int drain_pct);
		int total;
		tx_quiet = ($urandom_range(0, 3) == 0);
		rx_quiet = ($urandom_range(0, 3) == 0);
		total = frames * model_width * model_height;
		for (int i = 0; i < total; i++) begin
			if ($urandom_range(0, 99) < drain_pct) send_item(MODE_DRAIN, PIX_W'($urandom));
			send_item(MODE_PIXEL, random_pixel());
		end
		while (model_lag != 0) send_item(MODE_DRAIN, PIX_W'($urandom));
		settle();
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset kernel on a longer row and the shortest frame (0 clamps up)
	task automatic test_reset_kernel_wide_frame();
		load_config(40, 0, 1'b1);
		stream_frames(1, 0);
	endtask

	// 6x5 frame, all weights at maximum: drain on an empty pipe, pipeline fill,
	// an interior pixel passed through by a drain in mid-frame, saturation, frame end
	task automatic test_directed_frame();
		int total;
		foreach (kernel_plan[k]) kernel_plan[k] = '1;
		load_config(6, 2, 1'b0);
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		total = model_width * model_height;
		send_item(MODE_DRAIN, 8'hFF);	// nothing pending yet
		for (int i = 0; i < total; i++) begin
			// out position sits on the first interior pixel here
			if (i == total - 2) send_item(MODE_DRAIN, 8'h00);
			send_item(MODE_PIXEL, (i % 3 == 0) ? 8'hFF : ((i % 3 == 1) ? 8'h00 : PIX_W'($urandom)));
		end
		while (model_lag != 0) send_item(MODE_DRAIN, PIX_W'($urandom));
		send_item(MODE_DRAIN, PIX_W'($urandom));	// empty again
		settle();
	endtask

	// one tap class at a time, then an all-zero kernel
	task automatic test_each_weight();
		for (int sel = 0; sel <= NUM_WEIGHTS; sel++) begin
			foreach (kernel_plan[k]) kernel_plan[k] = '0;
			if (sel < NUM_WEIGHTS) kernel_plan[sel] = sel[0] ? '1 : weight_t'($urandom);
			load_config(5 + sel, 6, 1'b0);
			stream_frames(1, 0);
		end
	endtask

	// narrowest row with a tall frame
	task automatic test_tall_frame();
		foreach (kernel_plan[k]) kernel_plan[k] = weight_t'($urandom_range(0, 4000));
		load_config(5, 60, 1'b0);
		stream_frames(1, 0);
	endtask

	// random small sizes and kernels, one to three frames per setting, stray drains
	task automatic test_random_stream();
		int first_item;
		int width;
		int height;
		first_item = sent_items;
		while (sent_items - first_item < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0: foreach (kernel_plan[k]) kernel_plan[k] = WEIGHT_RESET[k];
				1: foreach (kernel_plan[k]) kernel_plan[k] = weight_t'($urandom_range(0, 5000));
				2: foreach (kernel_plan[k]) kernel_plan[k] = weight_t'($urandom);
				default: foreach (kernel_plan[k]) kernel_plan[k] = $urandom_range(0, 1) ? '1 : '0;
			endcase
			width  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
			height = $urandom_range(0, 9);
			load_config(width, height, 1'b0);
			stream_frames($urandom_range(1, 3), 4);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_kernel_wide_frame();
		test_directed_frame();
		test_each_weight();
		test_tall_frame();
		test_random_stream();
		settle();
		if (mismatch_count == 0) begin
			$display("** gaussian_blur_5x5: PASSED **");
		end else begin
			$display("** gaussian_blur_5x5: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/gbl_pkg.sv
hw/rtl/gbl_ram.sv
hw/rtl/gbl_cell.sv
hw/rtl/gbl_fifo.sv
hw/rtl/gaussian_blur_5x5.sv
verif/tb_gaussian_blur_5x5.sv
